FILE: design/pstbl_pkg.sv
package pstbl_pkg;

   // Result status codes carried on the response channel.
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_CAP     = 2'd1,
      STATUS_RATE    = 2'd2,
      STATUS_IGNORED = 2'd3
   } status_type;

   // Request kinds.
   localparam logic REQ_ACQUIRE = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   // Register indexes; register i lies at byte address 4*i.
   localparam int  CSR_ADDR_W = 4;
   localparam logic [1:0] REG_REFILL_RATE     = 2'd0;
   localparam logic [1:0] REG_BUCKET_CAPACITY = 2'd1;
   localparam logic [1:0] REG_MAX_IN_FLIGHT   = 2'd2;

   // Register reset values.
   localparam logic [15:0] REFILL_RATE_RESET     = 16'd6554;
   localparam logic [7:0]  BUCKET_CAPACITY_RESET = 8'd100;
   localparam logic [7:0]  MAX_IN_FLIGHT_RESET   = 8'd8;

   // Rate register fraction bits and the width of elapsed time times rate.
   localparam int RATE_FRAC = 16;
   localparam int PROD_W    = 48;

endpackage

FILE: design/per_source_token_bucket_limiter.sv
// Per-source token bucket limiter with a cap on requests in flight. Each request beat
// names a source and carries the current time in milliseconds; an acquire refills
// the source's bucket by elapsed time times refill_rate (saturating at
// bucket_capacity whole tokens) and is granted if the source is below max_in_flight
// and holds at least one token, while a release frees one in-flight slot. A request
// beat is taken into the input register and its response is then loaded into the
// result register, so one beat is taken every cycle while the response side keeps
// up; a stalled response holds the input once both registers are full. The rate is
// set by the read-modify-write of the per-source register table, with one 32 by 16
// bit multiply for the refill. Table entries are marked unused at reset, so no
// clearing pass is needed. Configuration is to be written through the APB-style
// port only while the block is idle; the block itself does not enforce this.
module per_source_token_bucket_limiter
   import pstbl_pkg::*;
#(
   parameter int NUM_SOURCES = 16,
   parameter int TIME_BITS   = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic [3:0]            req_source_id,
   input  logic [31:0]           req_now_time,
   // Response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_granted,
   output logic [1:0]            rsp_status,
   output logic [7:0]            rsp_in_flight_now,
   output logic [7:0]            rsp_tokens_whole,
   // Configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int IDX_W   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam int LEVEL_W = 8 + FRAC_BITS;
   localparam int SH_L    = (FRAC_BITS > RATE_FRAC) ? FRAC_BITS - RATE_FRAC : 0;
   localparam int SH_R    = (FRAC_BITS < RATE_FRAC) ? RATE_FRAC - FRAC_BITS : 0;
   localparam int ADD_W   = PROD_W + SH_L;
   localparam int SUM_W   = ADD_W + 1;

   // Configuration registers.
   logic [15:0] refill_rate_ff;
   logic [7:0]  bucket_capacity_ff;
   logic [7:0]  max_in_flight_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         refill_rate_ff     <= REFILL_RATE_RESET;
         bucket_capacity_ff <= BUCKET_CAPACITY_RESET;
         max_in_flight_ff   <= MAX_IN_FLIGHT_RESET;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_REFILL_RATE:     refill_rate_ff     <= pwdata[15:0];
            REG_BUCKET_CAPACITY: bucket_capacity_ff <= pwdata[7:0];
            REG_MAX_IN_FLIGHT:   max_in_flight_ff   <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (paddr[3:2])
         REG_REFILL_RATE:     prdata = {16'd0, refill_rate_ff};
         REG_BUCKET_CAPACITY: prdata = {24'd0, bucket_capacity_ff};
         REG_MAX_IN_FLIGHT:   prdata = {24'd0, max_in_flight_ff};
         default:             prdata = 32'd0;
      endcase
   end

   // Pipeline control: the input register moves on whenever the result register is
   // free or being emptied this cycle.
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s2_load, advance, s1_load;

   assign s2_load   = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && s2_load;
   assign req_stall = s1_valid_ff && !s2_load;
   assign s1_load   = req_valid && !req_stall;

   always_comb begin
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = s2_load ? advance : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register.
   logic                 s1_type_ff;
   logic [3:0]           s1_src_ff;
   logic [TIME_BITS-1:0] s1_now_ff;

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_type_ff <= req_type;
         s1_src_ff  <= req_source_id;
         s1_now_ff  <= TIME_BITS'(req_now_time);
      end
   end

   // Per-source table held in flip-flops.
   logic                 valid_ff    [NUM_SOURCES];
   logic [LEVEL_W-1:0]   level_ff    [NUM_SOURCES];
   logic [TIME_BITS-1:0] last_ff     [NUM_SOURCES];
   logic [7:0]           inflight_ff [NUM_SOURCES];

   logic [IDX_W-1:0]     idx;
   logic                 in_range;
   logic                 ent_valid;
   logic [LEVEL_W-1:0]   ent_level;
   logic [TIME_BITS-1:0] ent_last;
   logic [7:0]           ent_inflight;

   assign idx          = IDX_W'(s1_src_ff);
   assign in_range     = {5'd0, s1_src_ff} < 9'(NUM_SOURCES);
   assign ent_valid    = valid_ff[idx];
   assign ent_level    = level_ff[idx];
   assign ent_last     = last_ff[idx];
   assign ent_inflight = inflight_ff[idx];

   // Refill: an unused entry starts full at the current time with nothing in flight.
   logic [LEVEL_W-1:0]   cap_level;
   logic [LEVEL_W-1:0]   one_token;
   logic [LEVEL_W-1:0]   base_level;
   logic [TIME_BITS-1:0] base_last;
   logic [7:0]           base_inflight;
   logic [TIME_BITS-1:0] elapsed;
   logic                 elapsed_big;
   logic [PROD_W-1:0]    prod;
   logic [ADD_W-1:0]     add_scaled;
   logic [SUM_W-1:0]     add;
   logic [SUM_W-1:0]     sum;
   logic [LEVEL_W-1:0]   refilled;

   assign cap_level     = {bucket_capacity_ff, FRAC_BITS'(0)};
   assign one_token     = LEVEL_W'(1) << FRAC_BITS;
   assign base_level    = ent_valid ? ent_level : cap_level;
   assign base_last     = ent_valid ? ent_last : s1_now_ff;
   assign base_inflight = ent_valid ? ent_inflight : 8'd0;
   assign elapsed       = s1_now_ff - base_last;
   assign elapsed_big   = (TIME_BITS > 32) ? |(64'(elapsed) >> 32) : 1'b0;
   assign prod          = PROD_W'(32'(elapsed)) * PROD_W'(refill_rate_ff);
   assign add_scaled    = (ADD_W'(prod) << SH_L) >> SH_R;

   always_comb begin
      if (refill_rate_ff == 16'd0) begin
         add = '0;
      end else if (elapsed_big) begin
         add = SUM_W'(cap_level);
      end else begin
         add = SUM_W'(add_scaled);
      end
      sum = SUM_W'(base_level) + add;
      if (add >= SUM_W'(cap_level) || sum >= SUM_W'(cap_level)) begin
         refilled = cap_level;
      end else begin
         refilled = sum[LEVEL_W-1:0];
      end
   end

   // Decision and the new entry contents.
   logic               granted_in;
   status_type         status_in;
   logic [7:0]         inflight_in;
   logic [7:0]         whole_in;
   logic               ent_write;
   logic [LEVEL_W-1:0] level_in;

   always_comb begin
      granted_in  = 1'b0;
      status_in   = STATUS_IGNORED;
      inflight_in = 8'd0;
      level_in    = refilled;
      ent_write   = 1'b0;
      if (!in_range) begin
         status_in = (s1_type_ff == REQ_RELEASE) ? STATUS_IGNORED : STATUS_RATE;
         level_in  = '0;
      end else if (s1_type_ff == REQ_RELEASE) begin
         level_in = ent_level;
         if (!ent_valid) begin
            status_in = STATUS_IGNORED;
            level_in  = '0;
         end else if (ent_inflight != 8'd0) begin
            status_in   = STATUS_OK;
            inflight_in = ent_inflight - 8'd1;
            ent_write   = 1'b1;
         end else begin
            status_in   = STATUS_IGNORED;
            inflight_in = ent_inflight;
         end
      end else begin
         ent_write   = 1'b1;
         inflight_in = base_inflight;
         if (base_inflight >= max_in_flight_ff) begin
            status_in = STATUS_CAP;
         end else if (refilled < one_token) begin
            status_in = STATUS_RATE;
         end else begin
            status_in   = STATUS_OK;
            granted_in  = 1'b1;
            level_in    = refilled - one_token;
            inflight_in = base_inflight + 8'd1;
         end
      end
      whole_in = level_in[LEVEL_W-1:FRAC_BITS];
   end

   // Table update, at the cycle the beat leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SOURCES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (advance && ent_write) begin
         valid_ff[idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && ent_write) begin
         level_ff[idx]    <= level_in;
         last_ff[idx]     <= (s1_type_ff == REQ_RELEASE) ? ent_last : s1_now_ff;
         inflight_ff[idx] <= inflight_in;
      end
   end

   // Result register.
   logic       granted_ff;
   status_type status_ff;
   logic [7:0] inflight_now_ff;
   logic [7:0] whole_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         granted_ff      <= granted_in;
         status_ff       <= status_in;
         inflight_now_ff <= inflight_in;
         whole_ff        <= whole_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted       = granted_ff;
   assign rsp_status        = status_ff;
   assign rsp_in_flight_now = inflight_now_ff;
   assign rsp_tokens_whole  = whole_ff;

endmodule

FILE: design/pstbl_checker.sv
module pstbl_checker
   import pstbl_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_granted,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_in_flight_now,
   input logic [7:0] rsp_tokens_whole
);

   // A stalled response beat stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_granted) &&
         $stable(rsp_status) && $stable(rsp_in_flight_now) && $stable(rsp_tokens_whole))
      else $error("response beat changed while stalled");

   // A grant always reports success and leaves at least one request in flight.
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> rsp_status == STATUS_OK && rsp_in_flight_now != 8'd0)
      else $error("grant without success status or in-flight count");

   // A rate-limited acquire had less than one whole token.
   a_rate_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_RATE |-> !rsp_granted && rsp_tokens_whole == 8'd0)
      else $error("rate limited with a whole token left");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind per_source_token_bucket_limiter pstbl_checker u_pstbl_checker (.*);
